@@ hdl/lrukv_pkg.sv @@
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants of the LRU key/value store: the input and result
// words, the command and status groups between controller and datapath, and
// the register map of the configuration port.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;

  // Configuration port.
  localparam int          CAP_W        = 5;
  localparam logic [4:0]  CAP_RESET    = 5'd16;
  localparam int          ADDR_W       = 3;
  localparam logic        REG_CAPACITY = 1'b0;

  // Operation codes carried in the func field.
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // Value returned by a get that misses and by every put.
  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  // One input word.
  typedef struct packed {
    logic               func;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input word
    logic compare;  // compare all slots against the key
    logic select;   // pick the slot that this word works on
    logic update;   // write ranks, keys and values
    logic load;     // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the output register can take a new word
  } dp_status_t;

endpackage

@@ hdl/lrukv_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrukv_ctrl
// Sequencer of the LRU key/value store. It steps one word through compare,
// select, update and result phases and hands the datapath one command per
// phase.
// ----------------------------------------------------------------------------
module lrukv_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lrukv_pkg::dp_status_t status,
  output lrukv_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_COMPARE = 5'b00010,
    ST_SELECT  = 5'b00100,
    ST_UPDATE  = 5'b01000,
    ST_RESULT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_SELECT;
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        // Hold here until the output register has room.
        if (status.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A word is only taken when no other word is in flight.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_COMPARE))
    else $error("accepted word did not start the compare phase");

  // The result is loaded only in the result phase and only when the output register has room.
  a_load_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_RESULT) && status.out_free)
    else $error("result loaded outside the result phase");

  a_update_follows_select: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.select |=> cmd.update)
    else $error("update did not follow select");

endmodule

@@ hdl/lrukv_dp.sv @@
// ----------------------------------------------------------------------------
// lrukv_dp
// Datapath of the LRU key/value store: slot keys and valid bits, recency
// ranks, the value memory, the fill count and the output register.
// ----------------------------------------------------------------------------
module lrukv_dp #(
  parameter int DEPTH    = lrukv_pkg::DEPTH_DEF,
  parameter int KEY_BITS = lrukv_pkg::KEY_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lrukv_pkg::dp_cmd_t                   cmd,
  output lrukv_pkg::dp_status_t                status,
  input  lrukv_pkg::in_word_t                  in_data,
  input  logic [$clog2(DEPTH + 1)-1:0]         eff_cap,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output lrukv_pkg::out_word_t                 out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Stored state.
  logic [DEPTH-1:0]    valid_r;
  logic [KEY_BITS-1:0] tag_r   [DEPTH];
  logic [IDX_W-1:0]    age_r   [DEPTH];
  logic [CNT_W-1:0]    used_r;
  logic [31:0]         val_mem [DEPTH];

  // Per-word working registers.
  lrukv_pkg::in_word_t item_r;
  logic [KEY_BITS-1:0] key_r;
  logic [DEPTH-1:0]    match_r, oldest_r, free_r;
  logic                full_r, hit_r, evict_r, ins_r;
  logic [IDX_W-1:0]    slot_r;
  logic [31:0]         evkey_r, rdata_r;

  lrukv_pkg::out_word_t out_r;
  logic                 out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0] slot_nxt;
  logic [IDX_W-1:0] age_slot;
  logic             is_put;

  // Lowest-numbered set bit of a slot vector.
  function automatic logic [IDX_W-1:0] first_set(input logic [DEPTH-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  assign is_put   = (item_r.func == lrukv_pkg::FUNC_PUT);
  assign age_slot = age_r[slot_r];

  // Slot choice: the hit slot, else the least recent when full, else a free one.
  always_comb begin
    if (|match_r) begin
      slot_nxt = first_set(match_r);
    end else if (full_r) begin
      slot_nxt = first_set(oldest_r);
    end else begin
      slot_nxt = first_set(free_r);
    end
  end

  // Capture the word; the key is sign-extended or cut to the stored width.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
      key_r  <= KEY_BITS'(in_data.lookup_key);
    end
  end

  // Parallel tag compare, least-recent detect and free-slot vector.
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_r[i]  <= valid_r[i] && (tag_r[i] == key_r);
        oldest_r[i] <= valid_r[i] &&
                       (CNT_W'(age_r[i]) == used_r - CNT_W'(1));
        free_r[i]   <= !valid_r[i];
      end
      full_r <= (used_r >= eff_cap) && (used_r != '0);
    end
  end

  // Slot selection and the decision of what the word does.
  always_ff @(posedge clk) begin
    if (cmd.select) begin
      slot_r  <= slot_nxt;
      hit_r   <= |match_r;
      ins_r   <= is_put && !(|match_r);
      evict_r <= is_put && !(|match_r) && full_r;
    end
  end

  // Value memory: one read and one write port, both on the selected slot.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rdata_r <= val_mem[slot_r];
      if (is_put) begin
        val_mem[slot_r] <= item_r.write_value;
      end
    end
  end

  // Key of the slot being replaced, taken before it is overwritten.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      evkey_r <= 32'(tag_r[slot_r]);
      if (ins_r) begin
        tag_r[slot_r] <= key_r;
      end
    end
  end

  // Recency ranks: the touched or new slot becomes rank zero.
  always_ff @(posedge clk) begin
    if (cmd.update && (hit_r || ins_r)) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (IDX_W'(i) == slot_r) begin
          age_r[i] <= '0;
        end else if (valid_r[i] && (ins_r || (age_r[i] < age_slot))) begin
          age_r[i] <= age_r[i] + IDX_W'(1);
        end
      end
    end
  end

  // Valid bits and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
    end else if (cmd.update && ins_r) begin
      valid_r[slot_r] <= 1'b1;
      if (!evict_r) begin
        used_r <= used_r + CNT_W'(1);
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.hit         <= hit_r;
      out_r.read_value  <= (hit_r && !is_put) ? rdata_r : lrukv_pkg::MISS_VALUE;
      out_r.evicted     <= evict_r;
      out_r.evicted_key <= evict_r ? evkey_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign status.out_free = !out_valid_r || out_ready;

  // The fill count always equals the number of valid slots.
  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(used_r))
    else $error("fill count differs from valid slot count");

  // A key is held in at most one slot.
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.select |-> $onehot0(match_r))
    else $error("key matched more than one slot");

  // When the store is full exactly one slot holds the oldest rank.
  a_oldest_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.select && full_r) |-> $onehot(oldest_r))
    else $error("no unique least recent slot in a full store");

  // The fill never grows past the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= DEPTH)
    else $error("fill count beyond depth");

endmodule

@@ hdl/lru_key_value_store.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_store
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The sequencer walks compare, select, update and result phases for one word
// at a time and the value memory read is registered; a new word is taken only
// once the last word's result is loaded. A waiting result holds the sequencer
// in its result phase, so it blocks the next word.
// Reset (synchronous, active low) empties the store, clears the output
// register and sets the capacity register to 16.
// ----------------------------------------------------------------------------
module lru_key_value_store #(
  parameter int DEPTH    = lrukv_pkg::DEPTH_DEF,
  parameter int KEY_BITS = lrukv_pkg::KEY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lrukv_pkg::in_word_t              in_data,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output lrukv_pkg::out_word_t             out_data,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lrukv_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [lrukv_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]            eff_cap;
  logic                        reg_sel;
  lrukv_pkg::dp_cmd_t          cmd;
  lrukv_pkg::dp_status_t       status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == lrukv_pkg::REG_CAPACITY);

  // Capacity register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lrukv_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      cap_r <= pwdata[lrukv_pkg::CAP_W-1:0];
    end
  end

  // Register read-back.
  assign prdata = reg_sel ? 32'(cap_r) : '0;

  // Capacity clamped to the range one to depth.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_r) > DEPTH) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  lrukv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lrukv_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .eff_cap   (eff_cap),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU key/value store. A queue of get and put
// words feeds a valid/ready driver; a monitor predicts each accepted word
// against its own model of the slots, keys, values and recency ranks, and
// compares every result word field by field. The capacity register is
// rewritten between phases, and each phase idles and stalls the two
// channels in one of four patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = lrukv_pkg::DEPTH_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 90;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 158;
  localparam logic [lrukv_pkg::ADDR_W-1:0] CAP_ADDR   = {lrukv_pkg::REG_CAPACITY, 2'b00};
  localparam logic [lrukv_pkg::ADDR_W-1:0] SPARE_ADDR = 3'd4;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lrukv_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lrukv_pkg::out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lrukv_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Stimulus and expectation queues.
  lrukv_pkg::in_word_t  pending_words[$];
  lrukv_pkg::out_word_t results_due[$];

  // Idling control, set per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;

  // Shadow copy of the store used for prediction.
  logic [4:0]  cap_reg = lrukv_pkg::CAP_RESET;
  logic        slot_valid[DEPTH];
  logic [31:0] slot_key[DEPTH];
  logic [31:0] slot_value[DEPTH];
  int          slot_age[DEPTH];
  int          used_count = 0;

  // Run statistics.
  int errors = 0;
  int checked = 0;
  int get_cnt = 0;
  int put_cnt = 0;
  int hit_cnt = 0;
  int evict_cnt = 0;
  int idle_cycles = 0;

  logic [31:0] key_pool[32];

  lru_key_value_store dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Work out the result word of one accepted word and update the shadow store.
  function automatic lrukv_pkg::out_word_t predict_lookup(lrukv_pkg::in_word_t w);
    lrukv_pkg::out_word_t r;
    int found;
    int slot;
    int oldest;
    int eff;
    int prev_age;
    logic [31:0] key;
    key = w.lookup_key;
    r.hit = 1'b0;
    r.read_value = lrukv_pkg::MISS_VALUE;
    r.evicted = 1'b0;
    r.evicted_key = '0;
    found = -1;
    for (int i = 0; i < DEPTH; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (w.func == lrukv_pkg::FUNC_PUT) slot_value[found] = w.write_value;
      else r.read_value = slot_value[found];
      // Entries newer than the touched one age by one rank.
      prev_age = slot_age[found];
      for (int i = 0; i < DEPTH; i++)
        if (slot_valid[i] && i != found && slot_age[i] < prev_age) slot_age[i]++;
      slot_age[found] = 0;
    end else if (w.func == lrukv_pkg::FUNC_PUT) begin
      eff = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
      slot = -1;
      // A full store gives up its least recent entry first.
      if (used_count >= eff && used_count > 0) begin
        oldest = 0;
        for (int i = 0; i < DEPTH; i++)
          if (slot_valid[i] && (slot < 0 || slot_age[i] > oldest)) begin
            slot = i;
            oldest = slot_age[i];
          end
        if (slot >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[slot];
          slot_valid[slot] = 1'b0;
          used_count--;
        end
      end
      for (int i = 0; i < DEPTH; i++)
        if (slot < 0 && !slot_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < DEPTH; i++)
          if (slot_valid[i]) slot_age[i]++;
        slot_valid[slot] = 1'b1;
        slot_key[slot] = key;
        slot_value[slot] = w.write_value;
        slot_age[slot] = 0;
        used_count++;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic lrukv_pkg::in_word_t make_word(logic func, logic [31:0] key,
                                                    logic [31:0] val);
    lrukv_pkg::in_word_t w;
    w.func = func;
    w.lookup_key = key;
    w.write_value = val;
    return w;
  endfunction

  // Drive the input channel from the queue of pending words.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result channel ready, with random stalls and a single long hold-off.
  always @(posedge clk) begin
    int hold_left;
    int hold_served;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_served = 0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Predict accepted words, check result words and track register accesses.
  always @(posedge clk) begin
    lrukv_pkg::out_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = predict_lookup(in_data);
        results_due.push_back(want);
        if (in_data.func == lrukv_pkg::FUNC_PUT) put_cnt++;
        else get_cnt++;
        if (want.hit) hit_cnt++;
        if (want.evicted) evict_cnt++;
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word with none expected, got %h", $time, out_data);
          errors++;
        end else begin
          want = results_due.pop_front();
          checked++;
          check_field("hit", 32'(want.hit), 32'(out_data.hit));
          check_field("read_value", want.read_value, out_data.read_value);
          check_field("evicted", 32'(want.evicted), 32'(out_data.evicted));
          check_field("evicted_key", want.evicted_key, out_data.evicted_key);
        end
      end
      if (psel && penable && pready &&
          paddr[lrukv_pkg::ADDR_W-1:2] == lrukv_pkg::REG_CAPACITY) begin
        if (pwrite) cap_reg = pwdata[lrukv_pkg::CAP_W-1:0];
        else check_field("capacity readback", {27'b0, cap_reg}, prdata);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d words pending, %0d results due",
                 $time, idle_cycles, pending_words.size(), results_due.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // One register access: setup phase, then access phase.
  task automatic apb_xfer(input logic wr, input logic [lrukv_pkg::ADDR_W-1:0] addr,
                          input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || results_due.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_idle(idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SEND) ? 46 : (mode == IDLE_BOTH) ? 11 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 46 : (mode == IDLE_BOTH) ? 11 : 0;
  endtask

  // Random words: mostly keys from a small pool so hits and evictions occur.
  task automatic queue_random(int count, int span);
    logic [31:0] key;
    for (int n = 0; n < count; n++) begin
      key = ($urandom_range(3) != 0) ? key_pool[5'($urandom_range(span - 1))] : $urandom();
      pending_words.push_back(make_word(1'($urandom_range(1)), key, $urandom()));
    end
  endtask

  initial begin
    int caps[PHASES];
    int eff;
    caps = '{16, 8, 1, 0, 31, 16, 4, 17, 2, 12};
    for (int i = 0; i < DEPTH; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_age[i] = 0;
    end
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < 32; i++) key_pool[i] = $urandom();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset capacity: empty lookup, extreme keys and
    // values, update of a present key, then fill up and evict.
    set_idle(IDLE_NONE);
    pending_words.push_back(make_word(lrukv_pkg::FUNC_GET, 32'h0000_0000, 32'h1234_5678));
    pending_words.push_back(make_word(lrukv_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_words.push_back(make_word(lrukv_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_words.push_back(make_word(lrukv_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0000));
    pending_words.push_back(make_word(lrukv_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(lrukv_pkg::FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(lrukv_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000));
    pending_words.push_back(make_word(lrukv_pkg::FUNC_PUT, 32'h0000_0000, 32'hA5A5_A5A5));
    pending_words.push_back(make_word(lrukv_pkg::FUNC_GET, 32'h0000_0000, 32'h5A5A_5A5A));
    pending_words.push_back(make_word(lrukv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000));
    pending_words.push_back(make_word(lrukv_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000));
    for (int i = 0; i < 13; i++)
      pending_words.push_back(make_word(lrukv_pkg::FUNC_PUT, 32'd100 + i, $urandom()));
    wait_drained();

    // Random phases, each with its own capacity and idling pattern.
    for (int p = 0; p < PHASES; p++) begin
      apb_xfer(1'b1, CAP_ADDR, ($urandom() & ~32'h1F) | caps[p]);
      if (p == 3) apb_xfer(1'b1, SPARE_ADDR, $urandom());
      apb_xfer(1'b0, CAP_ADDR, '0);
      set_idle(idle_mode_t'(p % 4));
      eff = (caps[p] == 0) ? 1 : (caps[p] > DEPTH) ? DEPTH : caps[p];
      queue_random(PHASE_WORDS, (eff + 4 > 32) ? 32 : eff + 4);
      if (p == 5) hold_requests++;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_due.size());
      errors++;
    end
    $display("Checked %0d results: %0d gets, %0d puts, %0d hits, %0d evictions,",
             checked, get_cnt, put_cnt, hit_cnt, evict_cnt);
    $display("over %0d capacity settings with idle, stall and hold-off phases.", PHASES + 1);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
